>>> sv/spimf_pkg.sv
// ----------------------------------------------------------------------------
// spimf_pkg
// Shared types and constants for the SPI master with transmit/receive FIFOs.
// ----------------------------------------------------------------------------
package spimf_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [6:0] OFF_SRST  = 7'h40;
  localparam logic [6:0] OFF_CTRL  = 7'h60;
  localparam logic [6:0] OFF_STAT  = 7'h64;
  localparam logic [6:0] OFF_TXD   = 7'h68;
  localparam logic [6:0] OFF_RXD   = 7'h6C;
  localparam logic [6:0] OFF_SEL   = 7'h70;
  localparam logic [6:0] OFF_TXOCC = 7'h74;
  localparam logic [6:0] OFF_RXOCC = 7'h78;

  localparam logic [31:0] SRST_KEY = 32'h0000000A;

  // control register bit positions
  localparam int CR_ENABLE  = 1;
  localparam int CR_MASTER  = 2;
  localparam int CR_CPOL    = 3;
  localparam int CR_CPHA    = 4;
  localparam int CR_RXRST   = 6;
  localparam int CR_MANUAL  = 7;
  localparam int CR_INHIBIT = 8;
  localparam logic [8:0] CTRL_RESET = 9'h100;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  reg_offset;
    logic [31:0] write_data;
    logic        miso;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        sclk;
    logic        mosi;
    logic [7:0]  slave_select;
    logic        busy_res;
  } out_item_t;

  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // apply the captured item and register the result
  } dp_cmd_t;

endpackage

>>> sv/spimf_ctrl.sv
// ----------------------------------------------------------------------------
// spimf_ctrl
// Sequencer: accepts an item, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
module spimf_ctrl import spimf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (state_r == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item not executed");
  a_exec_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy) else $error("execute did not strobe result");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_valid) else $error("result without execute");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");

endmodule

>>> sv/spimf_dp.sv
// ----------------------------------------------------------------------------
// spimf_dp
// Register file, FIFOs, shifter and serial clock divider.
// ----------------------------------------------------------------------------
module spimf_dp import spimf_pkg::*; #(
  parameter int FIFO_DEPTH = 16,
  parameter int NUM_SLAVES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  output out_item_t out_data
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = CW + 1;

  in_item_t  item_r;
  out_item_t out_r, out_nxt;
  logic [7:0] hp_r;

  logic [8:0]            ctrl_r, ctrl_nxt;
  logic [NUM_SLAVES-1:0] sel_r, sel_nxt;
  logic [7:0]            tx_mem [FIFO_DEPTH];
  logic [7:0]            rx_mem [FIFO_DEPTH];
  logic [7:0]            tx_rd_r, rx_rd_r;
  logic [AW-1:0]         tx_head_r, tx_head_nxt, rx_head_r, rx_head_nxt;
  logic [CW-1:0]         tx_cnt_r, tx_cnt_nxt, rx_cnt_r, rx_cnt_nxt;
  logic [7:0]            shift_r, shift_nxt, rxb_r, rxb_nxt;
  logic [3:0]            bitc_r, bitc_nxt;
  logic [7:0]            div_r, div_nxt;
  logic                  lvl_r, lvl_nxt, shifting_r, shifting_nxt;

  logic          tx_we, rx_we;
  logic [AW-1:0] tx_waddr, rx_waddr;
  logic [7:0]    rx_wdata;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [CW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(FIFO_DEPTH)) s = s - SW'(FIFO_DEPTH);
    return s[AW-1:0];
  endfunction

  assign tx_waddr = wrap_add(tx_head_r, tx_cnt_r);
  assign rx_waddr = wrap_add(rx_head_r, rx_cnt_r);

  always_comb begin
    logic [8:0]  div9;
    logic [7:0]  hp_eff;
    logic        active;
    logic [31:0] rd;
    logic [31:0] ss_ext;
    logic [3:0]  bm1;
    logic [2:0]  idx;

    ctrl_nxt = ctrl_r;       sel_nxt = sel_r;
    tx_head_nxt = tx_head_r; tx_cnt_nxt = tx_cnt_r;
    rx_head_nxt = rx_head_r; rx_cnt_nxt = rx_cnt_r;
    shift_nxt = shift_r;     rxb_nxt = rxb_r;
    bitc_nxt = bitc_r;       div_nxt = div_r;
    lvl_nxt = lvl_r;         shifting_nxt = shifting_r;
    tx_we = 1'b0; rx_we = 1'b0; rx_wdata = rxb_r;
    rd = '0;
    hp_eff = (hp_r == 8'd0) ? 8'd1 : hp_r;
    div9 = {1'b0, div_r} + 9'd1;
    active = ctrl_r[CR_ENABLE] && ctrl_r[CR_MASTER] && !ctrl_r[CR_INHIBIT];

    unique case (action_t'(item_r.action))
      ACT_TICK: begin
        if (active) begin
          if (shifting_r) begin
            if (div9 >= {1'b0, hp_eff}) begin
              div_nxt = '0;
              lvl_nxt = ~lvl_r;
              if (ctrl_r[CR_CPHA] == bitc_r[0]) rxb_nxt = {rxb_r[6:0], item_r.miso};
              if (bitc_r == 4'd15) begin
                if (rx_cnt_r < CW'(FIFO_DEPTH)) begin
                  rx_we      = 1'b1;
                  rx_wdata   = rxb_nxt;
                  rx_cnt_nxt = rx_cnt_r + CW'(1);
                end
                shifting_nxt = 1'b0;
                bitc_nxt     = '0;
                lvl_nxt      = 1'b0;
              end else begin
                bitc_nxt = bitc_r + 4'd1;
              end
            end else begin
              div_nxt = div9[7:0];
            end
          end
          // load the next byte once the shifter is free
          if (!shifting_nxt && tx_cnt_r != '0) begin
            shift_nxt    = tx_rd_r;
            tx_head_nxt  = wrap_add(tx_head_r, CW'(1));
            tx_cnt_nxt   = tx_cnt_r - CW'(1);
            rxb_nxt      = '0;
            bitc_nxt     = '0;
            div_nxt      = '0;
            lvl_nxt      = 1'b0;
            shifting_nxt = 1'b1;
          end
        end
      end
      ACT_READ: begin
        unique case (item_r.reg_offset)
          OFF_CTRL:  rd = 32'(ctrl_r);
          OFF_STAT:  rd = {28'd0, tx_cnt_r >= CW'(FIFO_DEPTH), tx_cnt_r == '0,
                           rx_cnt_r >= CW'(FIFO_DEPTH), rx_cnt_r == '0};
          OFF_RXD: begin
            if (rx_cnt_r != '0) begin
              rd          = 32'(rx_rd_r);
              rx_head_nxt = wrap_add(rx_head_r, CW'(1));
              rx_cnt_nxt  = rx_cnt_r - CW'(1);
            end
          end
          OFF_SEL:   rd = 32'(sel_r);
          OFF_TXOCC: rd = 32'(tx_cnt_r);
          OFF_RXOCC: rd = (rx_cnt_r != '0) ? 32'(rx_cnt_r - CW'(1)) : '0;
          default:   rd = '0;
        endcase
      end
      ACT_WRITE: begin
        unique case (item_r.reg_offset)
          OFF_SRST: begin
            if (item_r.write_data == SRST_KEY) begin
              ctrl_nxt = CTRL_RESET;   sel_nxt = '1;
              tx_head_nxt = '0;        tx_cnt_nxt = '0;
              rx_head_nxt = '0;        rx_cnt_nxt = '0;
              shift_nxt = '0;          rxb_nxt = '0;
              bitc_nxt = '0;           div_nxt = '0;
              lvl_nxt = 1'b0;          shifting_nxt = 1'b0;
            end
          end
          OFF_CTRL: begin
            if (item_r.write_data[CR_RXRST]) rx_cnt_nxt = '0;
            ctrl_nxt = item_r.write_data[8:0];
            ctrl_nxt[CR_RXRST] = 1'b0;
          end
          OFF_TXD: begin
            if (tx_cnt_r < CW'(FIFO_DEPTH)) begin
              tx_we      = 1'b1;
              tx_cnt_nxt = tx_cnt_r + CW'(1);
            end
          end
          OFF_SEL: sel_nxt = item_r.write_data[NUM_SLAVES-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase

    // line levels after the update
    bm1 = bitc_nxt - 4'd1;
    if (ctrl_nxt[CR_CPHA]) idx = (bitc_nxt == '0) ? 3'd7 : 3'd7 - bm1[3:1];
    else                   idx = 3'd7 - bitc_nxt[3:1];
    ss_ext = '1;
    if (ctrl_nxt[CR_MANUAL] || shifting_nxt) ss_ext[NUM_SLAVES-1:0] = sel_nxt;

    out_nxt.read_data    = rd;
    out_nxt.sclk         = lvl_nxt ^ ctrl_nxt[CR_CPOL];
    out_nxt.mosi         = shifting_nxt ? shift_nxt[idx] : 1'b1;
    out_nxt.slave_select = ss_ext[7:0];
    out_nxt.busy_res     = shifting_nxt;
  end

  // head entries are registered on the accept edge, ahead of the execute cycle
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.exec) out_r <= out_nxt;
    if (cmd.exec && tx_we) tx_mem[tx_waddr] <= item_r.write_data[7:0];
    if (cmd.exec && rx_we) rx_mem[rx_waddr] <= rx_wdata;
    tx_rd_r <= tx_mem[tx_head_r];
    rx_rd_r <= rx_mem[rx_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r <= 8'd1;
      ctrl_r <= CTRL_RESET;  sel_r <= '1;
      tx_head_r <= '0;       tx_cnt_r <= '0;
      rx_head_r <= '0;       rx_cnt_r <= '0;
      shift_r <= '0;         rxb_r <= '0;
      bitc_r <= '0;          div_r <= '0;
      lvl_r <= 1'b0;         shifting_r <= 1'b0;
    end else begin
      if (cfg_we) hp_r <= cfg_wdata;
      if (cmd.exec) begin
        ctrl_r <= ctrl_nxt;        sel_r <= sel_nxt;
        tx_head_r <= tx_head_nxt;  tx_cnt_r <= tx_cnt_nxt;
        rx_head_r <= rx_head_nxt;  rx_cnt_r <= rx_cnt_nxt;
        shift_r <= shift_nxt;      rxb_r <= rxb_nxt;
        bitc_r <= bitc_nxt;        div_r <= div_nxt;
        lvl_r <= lvl_nxt;          shifting_r <= shifting_nxt;
      end
    end
  end

  assign out_data = out_r;

endmodule

>>> sv/spi_master_fifo_controller.sv
// ----------------------------------------------------------------------------
// spi_master_fifo_controller
// Register-mapped SPI master with byte-wide transmit and receive FIFOs.
//
//  channel  ports                      handshake
//  -------  -------------------------  -----------------------------------
//  input    start, busy, in_data       taken when start && !busy
//  result   out_valid, out_data        one-cycle strobe, cannot be stalled
//  config   cfg_we, cfg_wdata          written when cfg_we, no wait
//
// Each item passes through the accept cycle and the execute state in the
// controller; busy is high during execute. The result strobes in the cycle
// after execute, while the next item can already be accepted.
// Reset (rst_n low, synchronous) resets all control state; no clearing pass.
// ----------------------------------------------------------------------------
module spi_master_fifo_controller import spimf_pkg::*; #(
  parameter int FIFO_DEPTH = 16,
  parameter int NUM_SLAVES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  dp_cmd_t cmd;

  spimf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  spimf_dp #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .NUM_SLAVES (NUM_SLAVES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

>>> tb/spi_master_fifo_controller_test.sv
// ----------------------------------------------------------------------------
// spi_master_fifo_controller_test
// Drives ticks, register reads and register writes into the SPI master and
// compares every result against an in-bench model of the registers, FIFOs
// and shifter, across several serial clock half periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spi_master_fifo_controller_test;
  import spimf_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [7:0] SEL_ALL = 8'hFF;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  spi_master_fifo_controller dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // model state
  logic [7:0] half_period;
  logic [8:0] ctrl;
  logic [7:0] sel;
  logic [7:0] txq[$];
  logic [7:0] rxq[$];
  logic [7:0] shreg, rxbyte;
  logic [3:0] edges;
  logic [7:0] divcnt;
  logic       sclk_lvl;
  logic       shifting;

  out_item_t expected_q[$];
  int errors = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic void model_clear();
    ctrl = CTRL_RESET;
    sel = SEL_ALL;
    txq.delete();
    rxq.delete();
    shreg = '0;
    rxbyte = '0;
    edges = '0;
    divcnt = '0;
    sclk_lvl = 1'b0;
    shifting = 1'b0;
  endfunction

  function automatic void model_tick(input logic miso);
    logic [7:0] hp;
    hp = (half_period == 0) ? 8'd1 : half_period;
    if (!(ctrl[CR_ENABLE] && ctrl[CR_MASTER] && !ctrl[CR_INHIBIT])) return;
    if (shifting) begin
      divcnt++;
      if (divcnt >= hp) begin
        divcnt = '0;
        sclk_lvl = ~sclk_lvl;
        if (ctrl[CR_CPHA] == edges[0]) rxbyte = {rxbyte[6:0], miso};
        if (edges == 4'd15) begin
          if (rxq.size() < DEPTH) rxq.push_back(rxbyte);
          shifting = 1'b0;
          edges = '0;
          sclk_lvl = 1'b0;
        end else begin
          edges++;
        end
      end
    end
    if (!shifting && txq.size() != 0) begin
      shreg = txq.pop_front();
      rxbyte = '0;
      edges = '0;
      divcnt = '0;
      sclk_lvl = 1'b0;
      shifting = 1'b1;
    end
  endfunction

  function automatic logic [31:0] model_read(input logic [6:0] off);
    logic [31:0] v;
    v = '0;
    case (off)
      OFF_CTRL: v = {23'd0, ctrl};
      OFF_STAT: v = {28'd0, txq.size() >= DEPTH, txq.size() == 0,
                     rxq.size() >= DEPTH, rxq.size() == 0};
      OFF_RXD: if (rxq.size() != 0) v = {24'd0, rxq.pop_front()};
      OFF_SEL: v = {24'd0, sel};
      OFF_TXOCC: v = txq.size();
      OFF_RXOCC: v = (rxq.size() != 0) ? rxq.size() - 1 : 0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic void model_write(input logic [6:0] off, input logic [31:0] d);
    case (off)
      OFF_SRST: if (d == SRST_KEY) model_clear();
      OFF_CTRL: begin
        if (d[CR_RXRST]) rxq.delete();
        ctrl = d[8:0];
        ctrl[CR_RXRST] = 1'b0;
      end
      OFF_TXD: if (txq.size() < DEPTH) txq.push_back(d[7:0]);
      OFF_SEL: sel = d[7:0];
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_lines(input in_item_t it);
    out_item_t r;
    logic [2:0] idx;
    r = '0;
    case (action_t'(it.action))
      ACT_TICK: model_tick(it.miso);
      ACT_READ: r.read_data = model_read(it.reg_offset);
      ACT_WRITE: model_write(it.reg_offset, it.write_data);
      default: ;
    endcase
    r.mosi = 1'b1;
    if (shifting) begin
      if (ctrl[CR_CPHA]) idx = (edges == 0) ? 3'd7 : 3'd7 - 3'((edges - 4'd1) >> 1);
      else idx = 3'd7 - 3'(edges >> 1);
      r.mosi = shreg[idx];
    end
    r.sclk = sclk_lvl ^ ctrl[CR_CPOL];
    r.slave_select = (ctrl[CR_MANUAL] || shifting) ? sel : SEL_ALL;
    r.busy_res = shifting;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", out_data);
      end else begin
        out_item_t e;
        e = expected_q.pop_front();
        if (e !== out_data) begin
          errors++;
          if (mismatches++ < 10)
            $display({"mismatch: expected rd=%h sclk=%b mosi=%b ss=%h busy=%b,",
                      " got rd=%h sclk=%b mosi=%b ss=%h busy=%b"},
                     e.read_data, e.sclk, e.mosi, e.slave_select, e.busy_res,
                     out_data.read_data, out_data.sclk, out_data.mosi,
                     out_data.slave_select, out_data.busy_res);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input action_t act, input logic [6:0] off,
                           input logic [31:0] d, input logic miso);
    in_item_t it;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    it.action = act;
    it.reg_offset = off;
    it.write_data = d;
    it.miso = miso;
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_lines(it));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_half_period(input logic [7:0] hp);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= hp;
    @(posedge clk);
    cfg_we <= 1'b0;
    half_period = hp;
  endtask

  task automatic wr(input logic [6:0] off, input logic [31:0] d);
    send_item(ACT_WRITE, off, d, 1'b0);
  endtask

  task automatic rd(input logic [6:0] off);
    send_item(ACT_READ, off, $urandom, 1'b0);
  endtask

  task automatic tick();
    send_item(ACT_TICK, 7'($urandom), $urandom, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [31:0] active_ctrl();
    logic [31:0] c;
    c = $urandom & 32'hFFFF_FEBF;
    c[CR_ENABLE] = 1'b1;
    c[CR_MASTER] = 1'b1;
    c[CR_INHIBIT] = 1'b0;
    return c;
  endfunction

  task automatic test_register_map();
    rd(OFF_CTRL); rd(OFF_STAT); rd(OFF_SEL); rd(OFF_RXD); rd(OFF_RXOCC); rd(OFF_TXOCC);
    rd(OFF_SRST); rd(OFF_TXD); rd(7'h7F); rd(7'h00);
    wr(OFF_SEL, 32'hFFFF_FF5A); rd(OFF_SEL);
    wr(OFF_CTRL, 32'hFFFF_FFFF); rd(OFF_CTRL);
    wr(OFF_STAT, 32'hFFFF_FFFF); wr(7'h7F, 32'hFFFF_FFFF);
    wr(OFF_SRST, 32'h0000_000B); rd(OFF_CTRL);
    wr(OFF_SRST, SRST_KEY); rd(OFF_CTRL);
    send_item(ACT_NONE, OFF_TXD, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_fifo_limits();
    for (int i = 0; i < DEPTH + 2; i++) wr(OFF_TXD, $urandom);
    rd(OFF_STAT); rd(OFF_TXOCC);
    wr(OFF_CTRL, active_ctrl());
    repeat (20 * DEPTH) tick();
    rd(OFF_STAT); rd(OFF_RXOCC);
    for (int i = 0; i < 4; i++) rd(OFF_RXD);
    wr(OFF_CTRL, 32'h0000_0040); rd(OFF_STAT); rd(OFF_RXD);
  endtask

  task automatic test_transfers(input int n);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) tick();
      else if (r < 68) wr(OFF_TXD, $urandom);
      else if (r < 78) rd(OFF_RXD);
      else if (r < 83) wr(OFF_CTRL, ($urandom_range(0, 3) != 0) ? active_ctrl() : $urandom);
      else if (r < 86) wr(OFF_SEL, $urandom);
      else if (r < 92) rd($urandom_range(0, 1) ? 7'h60 + 7'($urandom_range(0, 6) * 4)
                                                : 7'($urandom));
      else if (r < 95) wr(7'($urandom), $urandom);
      else if (r < 96) wr(OFF_SRST, $urandom_range(0, 1) ? SRST_KEY : $urandom);
      else send_item(action_t'($urandom_range(0, 3)), 7'($urandom), $urandom,
                     1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    half_period = 8'd1;
    model_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_map();
    set_half_period(8'd0);
    test_fifo_limits();
    set_half_period(8'd1);
    test_transfers(150);
    set_half_period(8'd3);
    test_transfers(100);
    set_half_period(8'd255);
    wr(OFF_TXD, 32'h0000_00A5); wr(OFF_CTRL, active_ctrl());
    repeat (150) tick();
    rd(OFF_RXD);
    set_half_period(8'd2);
    test_transfers(100);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
